// ===== src/itj_pkg.sv =====
// ----------------------------------------------------------------------------
// itj_pkg
// Shared types and codes for the index tuple join engine.
// ----------------------------------------------------------------------------
package itj_pkg;

  localparam int FIELD_W  = 16;
  localparam int MAX_DIMS = 3;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_PROBE = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] CFG_A_MASK = 2'd0;
  localparam logic [1:0] CFG_B_MASK = 2'd1;

  localparam logic [2:0] A_MASK_RST = 3'd3;
  localparam logic [2:0] B_MASK_RST = 3'd5;

  typedef logic [MAX_DIMS-1:0][FIELD_W-1:0] tuple_t;

  typedef struct packed {
    logic [1:0] op;
    tuple_t     coord;
  } cmd_t;

endpackage

// ===== src/itj_front.sv =====
// ----------------------------------------------------------------------------
// itj_front
// Holds the dimension masks, accepts items, drops unused request codes and
// scatters the packed coordinates into a full tuple for the back end.
// ----------------------------------------------------------------------------
module itj_front import itj_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int NUM_DIMS    = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [2:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [FIELD_W-1:0] in_packed_value0,
  input  logic [FIELD_W-1:0] in_packed_value1,
  input  logic [FIELD_W-1:0] in_packed_value2,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd,
  output logic [2:0]         a_mask,
  output logic [2:0]         b_mask
);

  localparam int CW = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam logic [2:0] DIM_MASK = 3'((1 << NUM_DIMS) - 1);
  localparam logic [FIELD_W-1:0] CMASK = FIELD_W'((32'd1 << CW) - 32'd1);

  logic [2:0] a_mask_r;
  logic [2:0] b_mask_r;
  logic [2:0] m;
  logic [1:0] sel2;
  logic [FIELD_W-1:0] v [MAX_DIMS];
  logic [FIELD_W-1:0] pick2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_mask_r <= A_MASK_RST;
      b_mask_r <= B_MASK_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_A_MASK) begin
        a_mask_r <= cfg_data;
      end else if (cfg_index == CFG_B_MASK) begin
        b_mask_r <= cfg_data;
      end
    end
  end

  assign a_mask = a_mask_r;
  assign b_mask = b_mask_r;

  assign v[0] = in_packed_value0 & CMASK;
  assign v[1] = in_packed_value1 & CMASK;
  assign v[2] = in_packed_value2 & CMASK;

  assign m     = ((in_req_type == REQ_PROBE) ? b_mask_r : a_mask_r) & DIM_MASK;
  assign sel2  = {1'b0, m[0]} + {1'b0, m[1]};
  assign pick2 = (sel2 == 2'd0) ? v[0] : ((sel2 == 2'd1) ? v[1] : v[2]);

  always_comb begin
    q_cmd.op       = in_req_type;
    q_cmd.coord[0] = m[0] ? v[0] : '0;
    q_cmd.coord[1] = m[1] ? (m[0] ? v[1] : v[0]) : '0;
    q_cmd.coord[2] = m[2] ? pick2 : '0;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && (in_req_type == REQ_LOAD ||
                    in_req_type == REQ_PROBE || in_req_type == REQ_CLEAR);

endmodule

// ===== src/itj_queue.sv =====
// ----------------------------------------------------------------------------
// itj_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module itj_queue import itj_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_vld,
  output cmd_t head_cmd,
  input  logic pop
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign full     = (cnt_r == 2'd2);
  assign head_vld = (cnt_r != 2'd0);
  assign head_cmd = ent_r[rd_ptr_r];

endmodule

// ===== src/itj_back.sv =====
// ----------------------------------------------------------------------------
// itj_back
// Executes commands: appends loads to the tuple table until it is full, clears
// it, and scans it for probes, one stored tuple per cycle unless the output
// stalls, holding one match back so the final one can be flagged.
// ----------------------------------------------------------------------------
module itj_back import itj_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_WIDTH = 16,
  parameter int NUM_DIMS    = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         a_mask,
  input  logic [2:0]         b_mask,
  input  logic               q_vld,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] out_merged_coord0,
  output logic [FIELD_W-1:0] out_merged_coord1,
  output logic [FIELD_W-1:0] out_merged_coord2,
  output logic               out_last_match,
  output logic               out_table_overflowed
);

  localparam int CW   = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int EW   = NUM_DIMS * CW;
  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNTW-1:0] DEPTH_C = CNTW'(TABLE_DEPTH);
  localparam logic [2:0] DIM_MASK = 3'((1 << NUM_DIMS) - 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_data_r;
  logic [EW-1:0] wr_data;
  logic          wr_en;

  logic            state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CNTW-1:0] idx_r, idx_nxt;
  logic            c_vld_r, c_vld_nxt;
  logic [2:0]      common_r, common_nxt;
  tuple_t          probe_r, probe_nxt;
  tuple_t          pend_r, pend_nxt;
  logic            pend_vld_r, pend_vld_nxt;

  logic            out_vld_r;
  tuple_t          out_data_r;
  logic            out_last_r;
  logic            out_ovf_r;

  logic   advance;
  logic   issue;
  logic   hit;
  logic   o_load;
  logic   o_last;
  tuple_t stored;
  tuple_t merged;

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
    if (d < NUM_DIMS) begin : g_used
      assign stored[d] = FIELD_W'(rd_data_r[d*CW +: CW]);
      assign wr_data[d*CW +: CW] = q_cmd.coord[d][CW-1:0];
    end else begin : g_unused
      assign stored[d] = '0;
    end
    assign merged[d] = stored[d] | probe_r[d];
  end

  assign hit = (!common_r[0] || stored[0] == probe_r[0]) &&
               (!common_r[1] || stored[1] == probe_r[1]) &&
               (!common_r[2] || stored[2] == probe_r[2]);

  assign advance = !out_vld_r || !out_stall;
  assign issue   = (state_r == ST_SCAN) && advance && (idx_r < cnt_r);
  assign wr_en   = (state_r == ST_IDLE) && q_vld && (q_cmd.op == REQ_LOAD) &&
                   (cnt_r < DEPTH_C);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[AW-1:0]] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    idx_nxt      = idx_r;
    c_vld_nxt    = c_vld_r;
    common_nxt   = common_r;
    probe_nxt    = probe_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    q_pop        = 1'b0;
    o_load       = 1'b0;
    o_last       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_vld) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            REQ_LOAD: begin
              if (cnt_r < DEPTH_C) begin
                cnt_nxt = cnt_r + CNTW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            REQ_CLEAR: begin
              cnt_nxt = '0;
              ovf_nxt = 1'b0;
            end
            REQ_PROBE: begin
              probe_nxt    = q_cmd.coord;
              common_nxt   = a_mask & b_mask & DIM_MASK;
              idx_nxt      = '0;
              c_vld_nxt    = 1'b0;
              pend_vld_nxt = 1'b0;
              if (cnt_r != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (advance) begin
          c_vld_nxt = issue;
          if (issue) begin
            idx_nxt = idx_r + CNTW'(1);
          end
          if (c_vld_r) begin
            if (hit) begin
              if (pend_vld_r) begin
                o_load = 1'b1;
              end
              pend_nxt     = merged;
              pend_vld_nxt = 1'b1;
            end
          end else if (idx_r == cnt_r) begin
            if (pend_vld_r) begin
              o_load = 1'b1;
              o_last = 1'b1;
            end
            pend_vld_nxt = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      idx_r      <= '0;
      c_vld_r    <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      ovf_r      <= ovf_nxt;
      idx_r      <= idx_nxt;
      c_vld_r    <= c_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (o_load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    common_r <= common_nxt;
    probe_r  <= probe_nxt;
    pend_r   <= pend_nxt;
    if (o_load) begin
      out_data_r <= pend_r;
      out_last_r <= o_last;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_merged_coord0    = out_data_r[0];
  assign out_merged_coord1    = out_data_r[1];
  assign out_merged_coord2    = out_data_r[2];
  assign out_last_match       = out_last_r;
  assign out_table_overflowed = out_ovf_r;

endmodule

// ===== src/index_tuple_join.sv =====
// ----------------------------------------------------------------------------
// index_tuple_join
// Join engine for index tuples of up to three dimensions.
// ----------------------------------------------------------------------------
// The front end takes one item per cycle, unless the queue is full, into a
// two-entry command queue. A load or clear is executed as the back end pops
// it from the queue. A probe scans the table entries, up to TABLE_DEPTH of
// them: the tuple table is a memory with one registered read port, and the
// scan compares one stored tuple per cycle, emitting at most one result per
// cycle. Output stalls pause the scan. Results appear one match behind the
// scan so the final match of a probe can carry last_match.
module index_tuple_join import itj_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_WIDTH = 16,
  parameter int NUM_DIMS    = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [2:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [FIELD_W-1:0] in_packed_value0,
  input  logic [FIELD_W-1:0] in_packed_value1,
  input  logic [FIELD_W-1:0] in_packed_value2,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] out_merged_coord0,
  output logic [FIELD_W-1:0] out_merged_coord1,
  output logic [FIELD_W-1:0] out_merged_coord2,
  output logic               out_last_match,
  output logic               out_table_overflowed
);

  logic       q_full;
  logic       q_push;
  cmd_t       q_in;
  logic       q_vld;
  cmd_t       q_head;
  logic       q_pop;
  logic [2:0] a_mask;
  logic [2:0] b_mask;

  assign cfg_ready = 1'b1;

  itj_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .NUM_DIMS   (NUM_DIMS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_packed_value0(in_packed_value0),
    .in_packed_value1(in_packed_value1),
    .in_packed_value2(in_packed_value2),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_in),
    .a_mask          (a_mask),
    .b_mask          (b_mask)
  );

  itj_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_in),
    .full    (q_full),
    .head_vld(q_vld),
    .head_cmd(q_head),
    .pop     (q_pop)
  );

  itj_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COORD_WIDTH(COORD_WIDTH),
    .NUM_DIMS   (NUM_DIMS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .a_mask              (a_mask),
    .b_mask              (b_mask),
    .q_vld               (q_vld),
    .q_cmd               (q_head),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_merged_coord0   (out_merged_coord0),
    .out_merged_coord1   (out_merged_coord1),
    .out_merged_coord2   (out_merged_coord2),
    .out_last_match      (out_last_match),
    .out_table_overflowed(out_table_overflowed)
  );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the index tuple join engine. A queue of load,
// probe and clear items feeds a driver. Each item is predicted when the block
// accepts it, and a monitor compares every result with the oldest pending
// match. In most phases both sides idle at random, and one phase holds the result
// side off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;
  import itj_pkg::*;

  localparam int TABLE_DEPTH  = 64;
  localparam int DRAIN_CYCLES = 4 * (TABLE_DEPTH + 4);
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 250;
  localparam int PHASE_ITEMS  = 40;
  localparam int MAX_REPORTS  = 100;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    tuple_t coord;
    logic   last;
    logic   ovf;
  } match_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [2:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_req_type = '0;
  logic [FIELD_W-1:0] in_packed_value0 = '0;
  logic [FIELD_W-1:0] in_packed_value1 = '0;
  logic [FIELD_W-1:0] in_packed_value2 = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [FIELD_W-1:0] out_merged_coord0;
  logic [FIELD_W-1:0] out_merged_coord1;
  logic [FIELD_W-1:0] out_merged_coord2;
  logic               out_last_match;
  logic               out_table_overflowed;

  index_tuple_join u_dut (.*);

  tuple_t     stored_tuples [TABLE_DEPTH];
  int         stored_count = 0;
  logic       overflow_seen = 1'b0;
  logic [2:0] a_mask = A_MASK_RST;
  logic [2:0] b_mask = B_MASK_RST;

  match_t expected_matches [$];
  cmd_t   pending_items [$];
  cmd_t   offered;
  match_t want;
  tuple_t seen_coords;

  int   error_count = 0;
  int   cycle_count = 0;
  int   random_items = 0;
  int   phase_items = 0;
  int   in_idle_pct = 33;
  int   out_idle_pct = 33;
  logic hold_req = 1'b0;
  int   hold_cnt = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic tuple_t spread_coords(input tuple_t packed_in, input logic [2:0] mask);
    tuple_t t;
    int k;
    t = '0;
    k = 0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (mask[d]) begin
        t[d] = packed_in[k];
        k++;
      end
    end
    return t;
  endfunction

  function automatic void join_item(input cmd_t c);
    tuple_t     key;
    logic [2:0] common;
    match_t     prev;
    bit         have_prev;
    bit         hit;
    have_prev = 1'b0;
    prev = '0;
    case (c.op)
      REQ_CLEAR: begin
        stored_count = 0;
        overflow_seen = 1'b0;
      end
      REQ_LOAD: begin
        if (stored_count >= TABLE_DEPTH) begin
          overflow_seen = 1'b1;
        end else begin
          stored_tuples[stored_count] = spread_coords(c.coord, a_mask);
          stored_count++;
        end
      end
      REQ_PROBE: begin
        key = spread_coords(c.coord, b_mask);
        common = a_mask & b_mask;
        for (int i = 0; i < stored_count; i++) begin
          hit = 1'b1;
          for (int d = 0; d < MAX_DIMS; d++) begin
            if (common[d] && stored_tuples[i][d] != key[d]) hit = 1'b0;
          end
          if (hit) begin
            if (have_prev) expected_matches = {expected_matches, prev};
            prev.coord = stored_tuples[i] | key;
            prev.last = 1'b0;
            prev.ovf = overflow_seen;
            have_prev = 1'b1;
          end
        end
        if (have_prev) begin
          prev.last = 1'b1;
          expected_matches = {expected_matches, prev};
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < MAX_REPORTS) $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Driver: a new item is presented only once the current one is taken.
  always @(posedge clk) begin
    if (in_valid && !in_stall) join_item(offered);
    if (!in_valid || !in_stall) begin
      if (rst_n && pending_items.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        offered = pending_items.pop_front();
        in_valid <= 1'b1;
        in_req_type <= offered.op;
        in_packed_value0 <= offered.coord[0];
        in_packed_value1 <= offered.coord[1];
        in_packed_value2 <= offered.coord[2];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_matches.size() == 0) begin
        report_mismatch("result with no match pending");
      end else begin
        want = expected_matches.pop_front();
        seen_coords = {out_merged_coord2, out_merged_coord1, out_merged_coord0};
        for (int d = 0; d < MAX_DIMS; d++) begin
          if (seen_coords[d] !== want.coord[d]) begin
            report_mismatch($sformatf("merged_coord%0d is %h, expected %h",
                                      d, seen_coords[d], want.coord[d]));
          end
        end
        if (out_last_match !== want.last) begin
          report_mismatch($sformatf("last_match is %b, expected %b", out_last_match, want.last));
        end
        if (out_table_overflowed !== want.ovf) begin
          report_mismatch($sformatf("table_overflowed is %b, expected %b",
                                    out_table_overflowed, want.ovf));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic add_item(input logic [1:0] op, input logic [15:0] v0, v1, v2);
    cmd_t c;
    c.op = op;
    c.coord[0] = v0;
    c.coord[1] = v1;
    c.coord[2] = v2;
    pending_items = {pending_items, c};
    if (op != REQ_UNUSED) begin
      random_items++;
      phase_items++;
    end
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(9))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(1));
    endcase
  endfunction

  // Usually a clear, a run of loads, then probes, half reusing loaded values
  // so that matches are common. Now and then a stray item is mixed in.
  task automatic add_join_sequence(input bit fill_table);
    tuple_t loaded [$];
    tuple_t vals;
    int     n_loads;
    int     n_probes;
    if (fill_table || $urandom_range(9) < 7) begin
      add_item(REQ_CLEAR, pick_coord(), pick_coord(), pick_coord());
    end
    if (fill_table) n_loads = TABLE_DEPTH + 4;
    else if ($urandom_range(19) == 0) n_loads = $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 6);
    else n_loads = $urandom_range(1, 8);
    repeat (n_loads) begin
      for (int d = 0; d < MAX_DIMS; d++) vals[d] = pick_coord();
      add_item(REQ_LOAD, vals[0], vals[1], vals[2]);
      loaded = {loaded, vals};
    end
    if ($urandom_range(99) < 15) begin
      add_item(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
    n_probes = $urandom_range(1, 5);
    repeat (n_probes) begin
      if ($urandom_range(1)) begin
        vals = loaded[$urandom_range(loaded.size() - 1)];
      end else begin
        for (int d = 0; d < MAX_DIMS; d++) vals[d] = pick_coord();
      end
      add_item(REQ_PROBE, vals[0], vals[1], vals[2]);
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_matches.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_A_MASK: a_mask = val;
      CFG_B_MASK: b_mask = val;
      default: ;
    endcase
  endtask

  initial begin
    logic [2:0] a_set;
    logic [2:0] b_set;
    int         phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset masks: A carries dimensions 0 and 1, B carries 0 and 2.
    add_item(REQ_LOAD, 16'd1, 16'd2, 16'd3);
    add_item(REQ_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_item(REQ_LOAD, 16'd0, 16'd0, 16'd0);
    add_item(REQ_LOAD, 16'd1, 16'd7, 16'd9);
    add_item(REQ_PROBE, 16'd1, 16'h8000, 16'd4);
    add_item(REQ_PROBE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_item(REQ_PROBE, 16'd0, 16'd5, 16'd6);
    add_item(REQ_PROBE, 16'h1234, 16'd0, 16'd0);
    add_item(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_item(REQ_PROBE, 16'd1, 16'd0, 16'd0);
    add_item(REQ_CLEAR, 16'd0, 16'd0, 16'd0);
    add_item(REQ_PROBE, 16'd1, 16'd0, 16'd0);
    add_item(REQ_LOAD, 16'd5, 16'd6, 16'd7);
    add_item(REQ_PROBE, 16'd5, 16'd1, 16'd2);
    add_item(REQ_UNUSED, 16'd0, 16'd0, 16'd0);
    wait_idle();

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin a_set = 3'd7; b_set = 3'd7; end
        1: begin a_set = 3'd0; b_set = 3'd0; end
        2: begin a_set = 3'd7; b_set = 3'd0; end
        3: begin a_set = 3'd0; b_set = 3'd7; end
        default: begin a_set = 3'($urandom); b_set = 3'($urandom); end
      endcase
      if ($urandom_range(1)) begin
        write_reg(CFG_A_MASK, a_set);
        write_reg(CFG_B_MASK, b_set);
      end else begin
        write_reg(CFG_B_MASK, b_set);
        write_reg(CFG_A_MASK, a_set);
      end
      if (phase == 2) write_reg(CFG_UNUSED, 3'($urandom));
      in_idle_pct = (phase == 0 || phase == 3) ? 0 : 33;
      out_idle_pct = (phase == 0) ? 0 : 33;
      if (phase == 3) hold_req <= 1'b1;
      phase_items = 0;
      if (phase == 1) add_join_sequence(1'b1);
      while (phase_items < PHASE_ITEMS) add_join_sequence(1'b0);
      wait_idle();
      phase++;
    end

    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
